@@ rtl/core/programmable_dfa_recognizer_defines.svh @@
// Assertion macros shared by the checker of the programmable DFA recognizer.
// No dependencies; include by bare file name.
`ifndef PROGRAMMABLE_DFA_RECOGNIZER_DEFINES_SVH
`define PROGRAMMABLE_DFA_RECOGNIZER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PDR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pdr same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PDR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pdr next-cycle check failed");

`endif

@@ rtl/core/pdr_pkg.sv @@
// Package of the programmable DFA recognizer: field widths, codes and the link entry type.
// No dependencies.
package pdr_pkg;

  localparam int FUNC_W   = 3;
  localparam int IDX_W    = 4;
  localparam int SYM_W    = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD_ST   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADD_LINK = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_SET_KIND = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_WORD     = 3'd4;

  localparam logic [KIND_W-1:0] KIND_NORMAL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INITIAL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINAL   = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_NOSTART = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_STUCK   = 2'd2;

  localparam logic [SYM_W-1:0] CH_UPPER_A  = 8'h41;
  localparam logic [SYM_W-1:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [SYM_W-1:0] CASE_OFFSET = 8'h20;

  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] target;
  } link_t;

  localparam int LINK_W = $bits(link_t);

endpackage

@@ rtl/core/pdr_if.sv @@
// Valid/ready channel interfaces of the programmable DFA recognizer.
// Depends on pdr_pkg.
interface pdr_in_if;
  logic                         valid;
  logic                         ready;
  logic [pdr_pkg::FUNC_W-1:0]   func;
  logic [pdr_pkg::IDX_W-1:0]    from_state;
  logic [pdr_pkg::IDX_W-1:0]    to_state;
  logic [pdr_pkg::SYM_W-1:0]    symbol;
  logic [pdr_pkg::KIND_W-1:0]   kind;
  logic                         last;

  modport source(output valid, func, from_state, to_state, symbol, kind, last, input ready);
  modport sink(input valid, func, from_state, to_state, symbol, kind, last, output ready);
endinterface

interface pdr_out_if;
  logic                           valid;
  logic                           ready;
  logic                           accepted;
  logic [pdr_pkg::STATUS_W-1:0]   status;
  logic [pdr_pkg::IDX_W-1:0]      end_state;

  modport source(output valid, accepted, status, end_state, input ready);
  modport sink(input valid, accepted, status, end_state, output ready);
endinterface

@@ rtl/core/programmable_dfa_recognizer.sv @@
// Top level of the programmable DFA recognizer.
// Depends on pdr_pkg, pdr_in_if, pdr_out_if and pdr_ram.
//
// The block holds a small deterministic automaton that input transfers program and then
// query. The transition table lives in one synchronous RAM of MAX_STATES * 2^SYMBOL_BITS
// entries (4096 by default), addressed by source state and symbol, each entry a valid bit
// and a target state. A word symbol presents the table address in the idle state and uses
// the registered read data in the lookup state; the next symbol depends on the state this
// one leaves, so the block takes no new symbol until this lookup is done. An add-link
// transfer also goes through a read and then a conditional write, since the first link
// entered for a state and symbol wins. Add-state and set-type transfers need no further
// state. A word's last symbol also waits while an earlier result still sits unaccepted
// in the output register. After reset, and after a clear transfer that follows any link
// write, the block sweeps the table RAM one entry per cycle to mark every entry invalid,
// and in_ch.ready stays low meanwhile. A clear with no link written since the previous
// sweep finishes without one.
module programmable_dfa_recognizer #(
  parameter int MAX_STATES  = 16,
  parameter int SYMBOL_BITS = 8
) (
  input logic        clk,
  input logic        rst_n,
  pdr_in_if.sink     in_ch,
  pdr_out_if.source  out_ch
);

  localparam int ST_BITS = $clog2(MAX_STATES);
  localparam int ADDR_W  = ST_BITS + SYMBOL_BITS;
  localparam int DEPTH   = MAX_STATES << SYMBOL_BITS;
  localparam int CNT_W   = $clog2(MAX_STATES + 1);
  localparam int CMP_W   = (CNT_W > pdr_pkg::IDX_W) ? CNT_W : pdr_pkg::IDX_W;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  // Control sequencer, one-hot.
  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LINK  = 4'b0100,
    S_LOOK  = 4'b1000
  } ctl_state_t;

  ctl_state_t st_r, st_nxt;

  logic [ADDR_W-1:0]            clr_addr_r, clr_addr_nxt;
  logic                         dirty_r, dirty_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [pdr_pkg::IDX_W-1:0]    start_r, start_nxt;
  logic                         start_vld_r, start_vld_nxt;
  logic [MAX_STATES-1:0]        final_r, final_nxt;
  logic [pdr_pkg::IDX_W-1:0]    cur_r, cur_nxt;
  logic                         in_word_r, in_word_nxt;
  logic [pdr_pkg::STATUS_W-1:0] wstat_r, wstat_nxt;
  logic [ADDR_W-1:0]            hold_addr_r, hold_addr_nxt;
  logic [pdr_pkg::IDX_W-1:0]    hold_dst_r, hold_dst_nxt;
  logic                         hold_last_r, hold_last_nxt;
  logic                         hold_rd_r, hold_rd_nxt;
  logic                         out_vld_r, out_vld_nxt;
  logic                         out_acc_r, out_acc_nxt;
  logic [pdr_pkg::STATUS_W-1:0] out_stat_r, out_stat_nxt;
  logic [pdr_pkg::IDX_W-1:0]    out_end_r, out_end_nxt;

  // Table RAM ports.
  logic                        wr_en, rd_en;
  logic [ADDR_W-1:0]           wr_addr, rd_addr;
  logic [pdr_pkg::LINK_W-1:0]  wr_data, rd_data;
  pdr_pkg::link_t              rd_link, wr_link;

  // Decode of the incoming transfer.
  logic                        accept;
  logic                        src_known, dst_known, sym_upper;
  logic [pdr_pkg::SYM_W-1:0]   link_sym;
  logic [pdr_pkg::STATUS_W-1:0] eff_stat;
  logic [pdr_pkg::IDX_W-1:0]   eff_cur;

  // Completion of a lookup.
  logic                        hit, out_free;
  logic [pdr_pkg::STATUS_W-1:0] fin_stat;
  logic [pdr_pkg::IDX_W-1:0]   fin_cur;

  pdr_ram #(
    .WIDTH(pdr_pkg::LINK_W),
    .DEPTH(DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign rd_link = pdr_pkg::link_t'(rd_data);
  assign wr_data = pdr_pkg::LINK_W'(wr_link);

  assign in_ch.ready      = (st_r == S_IDLE);
  assign accept           = in_ch.valid && in_ch.ready;
  assign out_ch.valid     = out_vld_r;
  assign out_ch.accepted  = out_acc_r;
  assign out_ch.status    = out_stat_r;
  assign out_ch.end_state = out_end_r;
  assign out_free         = !out_vld_r || out_ch.ready;

  // Input decode: state range checks, uppercase detection and link symbol folding.
  always_comb begin
    src_known = CMP_W'(in_ch.from_state) < CMP_W'(cnt_r);
    dst_known = CMP_W'(in_ch.to_state) < CMP_W'(cnt_r);
    sym_upper = in_ch.symbol inside {[pdr_pkg::CH_UPPER_A : pdr_pkg::CH_UPPER_Z]};
    link_sym  = sym_upper ? (in_ch.symbol + pdr_pkg::CASE_OFFSET) : in_ch.symbol;
    // The first symbol of a word picks up the start state, or flags its absence.
    if (in_word_r) begin
      eff_stat = wstat_r;
      eff_cur  = cur_r;
    end else if (start_vld_r && (CMP_W'(start_r) < CMP_W'(cnt_r))) begin
      eff_stat = pdr_pkg::STAT_OK;
      eff_cur  = start_r;
    end else begin
      eff_stat = pdr_pkg::STAT_NOSTART;
      eff_cur  = '0;
    end
  end

  // Outcome of a word symbol in the lookup state. A target that is not a known state
  // counts as a missing transition.
  always_comb begin
    hit = hold_rd_r && rd_link.valid && (CMP_W'(rd_link.target) < CMP_W'(cnt_r));
    if (!hold_rd_r) begin
      fin_stat = wstat_r;
      fin_cur  = cur_r;
    end else if (hit) begin
      fin_stat = pdr_pkg::STAT_OK;
      fin_cur  = rd_link.target;
    end else begin
      fin_stat = pdr_pkg::STAT_STUCK;
      fin_cur  = cur_r;
    end
  end

  always_comb begin
    st_nxt        = st_r;
    clr_addr_nxt  = clr_addr_r;
    dirty_nxt     = dirty_r;
    cnt_nxt       = cnt_r;
    start_nxt     = start_r;
    start_vld_nxt = start_vld_r;
    final_nxt     = final_r;
    cur_nxt       = cur_r;
    in_word_nxt   = in_word_r;
    wstat_nxt     = wstat_r;
    hold_addr_nxt = hold_addr_r;
    hold_dst_nxt  = hold_dst_r;
    hold_last_nxt = hold_last_r;
    hold_rd_nxt   = hold_rd_r;
    out_vld_nxt   = out_vld_r && !out_ch.ready;
    out_acc_nxt   = out_acc_r;
    out_stat_nxt  = out_stat_r;
    out_end_nxt   = out_end_r;

    wr_en   = 1'b0;
    wr_addr = clr_addr_r;
    wr_link = '0;
    rd_en   = 1'b0;
    rd_addr = {ST_BITS'(eff_cur), in_ch.symbol[SYMBOL_BITS-1:0]};

    case (st_r)
      S_CLEAR: begin
        // Invalidate one table entry per cycle.
        wr_en        = 1'b1;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          st_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          case (in_ch.func)
            pdr_pkg::FUNC_CLEAR: begin
              cnt_nxt       = '0;
              start_nxt     = '0;
              start_vld_nxt = 1'b0;
              final_nxt     = '0;
              cur_nxt       = '0;
              in_word_nxt   = 1'b0;
              wstat_nxt     = pdr_pkg::STAT_OK;
              if (dirty_r) begin
                dirty_nxt    = 1'b0;
                clr_addr_nxt = '0;
                st_nxt       = S_CLEAR;
              end
            end

            pdr_pkg::FUNC_ADD_ST: begin
              if (cnt_r < CNT_W'(MAX_STATES)) begin
                final_nxt[ST_BITS'(cnt_r)] = 1'b0;
                cnt_nxt = cnt_r + 1'b1;
              end
            end

            pdr_pkg::FUNC_ADD_LINK: begin
              if (src_known && dst_known) begin
                rd_en         = 1'b1;
                rd_addr       = {ST_BITS'(in_ch.from_state), link_sym[SYMBOL_BITS-1:0]};
                hold_addr_nxt = rd_addr;
                hold_dst_nxt  = in_ch.to_state;
                st_nxt        = S_LINK;
              end
            end

            pdr_pkg::FUNC_SET_KIND: begin
              if (src_known) begin
                case (in_ch.kind)
                  pdr_pkg::KIND_NORMAL: begin
                    final_nxt[ST_BITS'(in_ch.from_state)] = 1'b0;
                  end
                  pdr_pkg::KIND_INITIAL: begin
                    final_nxt[ST_BITS'(in_ch.from_state)] = 1'b0;
                    start_nxt     = in_ch.from_state;
                    start_vld_nxt = 1'b1;
                  end
                  pdr_pkg::KIND_FINAL: begin
                    final_nxt[ST_BITS'(in_ch.from_state)] = 1'b1;
                  end
                  default: begin
                  end
                endcase
              end
            end

            pdr_pkg::FUNC_WORD: begin
              // Uppercase letters never match a stored link: treat as a miss at once.
              in_word_nxt   = 1'b1;
              cur_nxt       = eff_cur;
              hold_last_nxt = in_ch.last;
              hold_rd_nxt   = 1'b0;
              st_nxt        = S_LOOK;
              if (eff_stat != pdr_pkg::STAT_OK) begin
                wstat_nxt = eff_stat;
              end else if (sym_upper) begin
                wstat_nxt = pdr_pkg::STAT_STUCK;
              end else begin
                wstat_nxt   = pdr_pkg::STAT_OK;
                rd_en       = 1'b1;
                hold_rd_nxt = 1'b1;
              end
            end

            default: begin
            end
          endcase
        end
      end

      S_LINK: begin
        // Write only when the slot is still empty, so the first link stays.
        if (!rd_link.valid) begin
          wr_en          = 1'b1;
          wr_addr        = hold_addr_r;
          wr_link.valid  = 1'b1;
          wr_link.target = hold_dst_r;
          dirty_nxt      = 1'b1;
        end
        st_nxt = S_IDLE;
      end

      S_LOOK: begin
        if (!hold_last_r) begin
          cur_nxt   = fin_cur;
          wstat_nxt = fin_stat;
          st_nxt    = S_IDLE;
        end else if (out_free) begin
          cur_nxt      = fin_cur;
          wstat_nxt    = pdr_pkg::STAT_OK;
          in_word_nxt  = 1'b0;
          out_vld_nxt  = 1'b1;
          out_stat_nxt = fin_stat;
          out_acc_nxt  = (fin_stat == pdr_pkg::STAT_OK) && final_r[ST_BITS'(fin_cur)];
          out_end_nxt  = (fin_stat == pdr_pkg::STAT_NOSTART) ? '0 : fin_cur;
          st_nxt       = S_IDLE;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      clr_addr_r  <= '0;
      dirty_r     <= 1'b0;
      cnt_r       <= '0;
      start_r     <= '0;
      start_vld_r <= 1'b0;
      final_r     <= '0;
      cur_r       <= '0;
      in_word_r   <= 1'b0;
      wstat_r     <= pdr_pkg::STAT_OK;
      hold_rd_r   <= 1'b0;
      hold_last_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_addr_r  <= clr_addr_nxt;
      dirty_r     <= dirty_nxt;
      cnt_r       <= cnt_nxt;
      start_r     <= start_nxt;
      start_vld_r <= start_vld_nxt;
      final_r     <= final_nxt;
      cur_r       <= cur_nxt;
      in_word_r   <= in_word_nxt;
      wstat_r     <= wstat_nxt;
      hold_rd_r   <= hold_rd_nxt;
      hold_last_r <= hold_last_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hold_addr_r <= hold_addr_nxt;
    hold_dst_r  <= hold_dst_nxt;
    out_acc_r   <= out_acc_nxt;
    out_stat_r  <= out_stat_nxt;
    out_end_r   <= out_end_nxt;
  end

endmodule

@@ rtl/core/pdr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module pdr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/core/pdr_checker.sv @@
// Port-level checker of the programmable DFA recognizer, bound to the top level.
// Depends on pdr_pkg and programmable_dfa_recognizer_defines.svh.
`include "programmable_dfa_recognizer_defines.svh"

module pdr_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic [pdr_pkg::FUNC_W-1:0]   in_func,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_accepted,
  input logic [pdr_pkg::STATUS_W-1:0] out_status,
  input logic [pdr_pkg::IDX_W-1:0]    out_end_state
);

  // A stalled result is not withdrawn.
  `PDR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

  // After a word symbol is taken, the input is not ready while the lookup state is held.
  `PDR_ASSERT_NEXT(a_word_two_cycles, clk, rst_n,
    in_valid && in_ready && in_func == pdr_pkg::FUNC_WORD, !in_ready)

  // Only a word with status OK can be accepted.
  `PDR_ASSERT_IMPLIES(a_acc_ok, clk, rst_n, out_valid && out_accepted,
    out_status == pdr_pkg::STAT_OK)

  // A word without a start state reports state zero.
  `PDR_ASSERT_IMPLIES(a_nostart_end, clk, rst_n,
    out_valid && out_status == pdr_pkg::STAT_NOSTART, out_end_state == '0)

  // The status is one of the three defined outcomes.
  `PDR_ASSERT_IMPLIES(a_status_code, clk, rst_n, out_valid,
    out_status == pdr_pkg::STAT_OK || out_status == pdr_pkg::STAT_NOSTART ||
    out_status == pdr_pkg::STAT_STUCK)

endmodule

bind programmable_dfa_recognizer pdr_checker u_pdr_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .in_func      (in_ch.func),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_accepted (out_ch.accepted),
  .out_status   (out_ch.status),
  .out_end_state(out_ch.end_state)
);
